// ===== hw/rtl/pip_pkg.sv =====
`default_nettype none

package pip_pkg;

    // Coordinate format of vertices and test point
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // Vertex count saturates at the smallest valid polygon size
    localparam int MIN_VERTICES = 3;
    localparam int CNT_W        = $clog2(MIN_VERTICES + 1);

    // Queue between front and back
    localparam int MQ_DEPTH = 4;
    localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
    localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);

    // Result queue at the back
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef logic [CNT_W-1:0]          count_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // One classified vertex: open edge prev->cur, closing edge cur->first
    typedef struct packed {
        coord_t vx;
        coord_t vy;
        coord_t ox;
        coord_t oy;
        coord_t fx;
        coord_t fy;
        coord_t px;
        coord_t py;
        logic   has_open;
        logic   last;
        logic   too_few;
    } edge_req_t;

    // Queue status seen by its producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } mq_status_t;

    // Operands of one edge test after ordering by x
    typedef struct packed {
        logic  span;
        diff_t d_py;
        diff_t d_rx;
        diff_t d_ry;
        diff_t d_px;
    } edge_ops_t;

    typedef struct packed {
        logic in_poly;
        logic too_few;
    } result_t;

    // Order the endpoints by x, form differences and the half-open span test
    function automatic edge_ops_t edge_prep(coord_t nx, coord_t ny, coord_t ox, coord_t oy,
                                            coord_t px, coord_t py);
        edge_ops_t ops;
        coord_t    lx;
        coord_t    ly;
        coord_t    rx;
        coord_t    ry;
        if (nx > ox)
        begin
            lx = ox;
            ly = oy;
            rx = nx;
            ry = ny;
        end
        else
        begin
            lx = nx;
            ly = ny;
            rx = ox;
            ry = oy;
        end
        ops.span = ((nx < px) == (px <= ox));
        ops.d_py = diff_t'(py) - diff_t'(ly);
        ops.d_rx = diff_t'(rx) - diff_t'(lx);
        ops.d_ry = diff_t'(ry) - diff_t'(ly);
        ops.d_px = diff_t'(px) - diff_t'(lx);
        return ops;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pip_front.sv =====
`default_nettype none

module pip_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  pip_pkg::coord_t      vertex_x,
    input  pip_pkg::coord_t      vertex_y,
    input  pip_pkg::coord_t      point_x,
    input  pip_pkg::coord_t      point_y,
    input  wire                  last_vertex,
    input  wire                  push,
    output logic                 full,
    input  pip_pkg::mq_status_t  mq_status,
    output logic                 mq_push,
    output pip_pkg::edge_req_t   mq_req
);
    import pip_pkg::*;

    coord_t first_x_reg, first_x_next;
    coord_t first_y_reg, first_y_next;
    coord_t prev_x_reg, prev_x_next;
    coord_t prev_y_reg, prev_y_next;
    count_t cnt_reg, cnt_next;
    count_t cnt_inc;
    logic   accept;

    // Accept a request while the queue has room
    assign full    = mq_status.full;
    assign accept  = push && !mq_status.full;
    assign mq_push = accept;

    // Count vertices, saturating at the minimum polygon size
    assign cnt_inc = (cnt_reg == count_t'(MIN_VERTICES)) ? cnt_reg : cnt_reg + count_t'(1);

    // Classify the vertex into its edge tests
    always_comb
    begin
        mq_req.vx       = vertex_x;
        mq_req.vy       = vertex_y;
        mq_req.ox       = prev_x_reg;
        mq_req.oy       = prev_y_reg;
        mq_req.fx       = (cnt_reg == '0) ? vertex_x : first_x_reg;
        mq_req.fy       = (cnt_reg == '0) ? vertex_y : first_y_reg;
        mq_req.px       = point_x;
        mq_req.py       = point_y;
        mq_req.has_open = (cnt_reg != '0);
        mq_req.last     = last_vertex;
        mq_req.too_few  = (cnt_inc < count_t'(MIN_VERTICES));
    end

    // Advance the polygon state, clear it after the closing vertex
    always_comb
    begin
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        cnt_next     = cnt_reg;
        if (accept)
        begin
            if (last_vertex)
            begin
                first_x_next = '0;
                first_y_next = '0;
                prev_x_next  = '0;
                prev_y_next  = '0;
                cnt_next     = '0;
            end
            else
            begin
                if (cnt_reg == '0)
                begin
                    first_x_next = vertex_x;
                    first_y_next = vertex_y;
                end
                prev_x_next = vertex_x;
                prev_y_next = vertex_y;
                cnt_next    = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            cnt_reg     <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_vertex) |=> (cnt_reg == '0 && prev_x_reg == '0))
        else $error("polygon state not cleared after closing vertex");
    a_first_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !last_vertex && cnt_reg == '0) |=>
        (first_x_reg == $past(vertex_x) && first_y_reg == $past(vertex_y)))
        else $error("first vertex not captured");
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(cnt_reg))
        else $error("vertex count moved without a request");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pip_mid_queue.sv =====
`default_nettype none

module pip_mid_queue (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_en,
    input  pip_pkg::edge_req_t   wr_req,
    input  wire                  rd_en,
    output pip_pkg::edge_req_t   rd_req,
    output pip_pkg::mq_status_t  status
);
    import pip_pkg::*;

    edge_req_t             entries_reg [MQ_DEPTH];
    logic [MQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [MQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [MQ_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                  do_wr;
    logic                  do_rd;

    assign status.full  = (cnt_reg == MQ_CNT_W'(MQ_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_req       = entries_reg[rd_ptr_reg];

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + MQ_CNT_W'(do_wr) - MQ_CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the request payload
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_req;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MQ_CNT_W'(MQ_DEPTH))
        else $error("mid queue fill level out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("mid queue pointers disagree with empty level");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("mid queue level did not grow on write");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pip_back.sv =====
`default_nettype none

module pip_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  pip_pkg::edge_req_t   mq_req,
    input  pip_pkg::mq_status_t  mq_status,
    output logic                 mq_pop,
    output logic                 empty,
    input  wire                  pop,
    output logic                 inside_res,
    output logic                 too_few
);
    import pip_pkg::*;

    // Stage 1: ordered operands
    logic       s1_v_reg;
    logic       s1_last_reg;
    logic       s1_too_few_reg;
    logic       s1_has_open_reg;
    edge_ops_t  s1_ops_a_reg;
    edge_ops_t  s1_ops_b_reg;

    // Stage 2: products
    logic       s2_v_reg;
    logic       s2_last_reg;
    logic       s2_too_few_reg;
    logic       s2_has_open_reg;
    logic       s2_span_a_reg;
    logic       s2_span_b_reg;
    prod_t      s2_pa1_reg;
    prod_t      s2_pa2_reg;
    prod_t      s2_pb1_reg;
    prod_t      s2_pb2_reg;

    logic       flag_reg, flag_next;
    logic       cross_a;
    logic       cross_b;
    logic       flag_upd;

    // Result queue
    result_t               oq_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   oq_wr_ptr_reg, oq_wr_ptr_next;
    logic [OQ_PTR_W-1:0]   oq_rd_ptr_reg, oq_rd_ptr_next;
    logic [OQ_CNT_W-1:0]   oq_cnt_reg, oq_cnt_next;
    logic [OQ_CNT_W-1:0]   in_flight;
    logic                  oq_wr;
    logic                  oq_rd;
    result_t               oq_wdata;

    // Issue only when every result in flight has a slot reserved
    assign in_flight = OQ_CNT_W'(s1_v_reg && s1_last_reg) + OQ_CNT_W'(s2_v_reg && s2_last_reg);
    assign mq_pop    = !mq_status.empty
                       && ((oq_cnt_reg + in_flight) < OQ_CNT_W'(OQ_DEPTH));

    // Stage 1 and stage 2 valid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= mq_pop;
            s2_v_reg <= s1_v_reg;
        end
    end

    // Order endpoints and form differences for both edges
    always_ff @(posedge clk)
    begin
        s1_last_reg     <= mq_req.last;
        s1_too_few_reg  <= mq_req.too_few;
        s1_has_open_reg <= mq_req.has_open;
        s1_ops_a_reg    <= edge_prep(mq_req.vx, mq_req.vy, mq_req.ox, mq_req.oy,
                                     mq_req.px, mq_req.py);
        s1_ops_b_reg    <= edge_prep(mq_req.fx, mq_req.fy, mq_req.vx, mq_req.vy,
                                     mq_req.px, mq_req.py);
    end

    // Multiply the cross-product terms
    always_ff @(posedge clk)
    begin
        s2_last_reg     <= s1_last_reg;
        s2_too_few_reg  <= s1_too_few_reg;
        s2_has_open_reg <= s1_has_open_reg;
        s2_span_a_reg   <= s1_ops_a_reg.span;
        s2_span_b_reg   <= s1_ops_b_reg.span;
        s2_pa1_reg      <= s1_ops_a_reg.d_py * s1_ops_a_reg.d_rx;
        s2_pa2_reg      <= s1_ops_a_reg.d_ry * s1_ops_a_reg.d_px;
        s2_pb1_reg      <= s1_ops_b_reg.d_py * s1_ops_b_reg.d_rx;
        s2_pb2_reg      <= s1_ops_b_reg.d_ry * s1_ops_b_reg.d_px;
    end

    // Compare products and toggle the crossing parity
    assign cross_a  = s2_has_open_reg && s2_span_a_reg && (s2_pa1_reg < s2_pa2_reg);
    assign cross_b  = s2_last_reg && s2_span_b_reg && (s2_pb1_reg < s2_pb2_reg);
    assign flag_upd = flag_reg ^ cross_a ^ cross_b;

    always_comb
    begin
        flag_next = flag_reg;
        if (s2_v_reg)
        begin
            flag_next = s2_last_reg ? 1'b0 : flag_upd;
        end
    end

    assign oq_wr            = s2_v_reg && s2_last_reg;
    assign oq_wdata.in_poly = flag_upd && !s2_too_few_reg;
    assign oq_wdata.too_few = s2_too_few_reg;

    // Drain results to the output side
    assign empty      = (oq_cnt_reg == '0);
    assign oq_rd      = pop && !empty;
    assign inside_res = oq_reg[oq_rd_ptr_reg].in_poly;
    assign too_few    = oq_reg[oq_rd_ptr_reg].too_few;

    always_comb
    begin
        oq_wr_ptr_next = oq_wr_ptr_reg;
        oq_rd_ptr_next = oq_rd_ptr_reg;
        if (oq_wr)
        begin
            oq_wr_ptr_next = (oq_wr_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                        : oq_wr_ptr_reg + 1'b1;
        end
        if (oq_rd)
        begin
            oq_rd_ptr_next = (oq_rd_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                                        : oq_rd_ptr_reg + 1'b1;
        end
        oq_cnt_next = oq_cnt_reg + OQ_CNT_W'(oq_wr) - OQ_CNT_W'(oq_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg      <= 1'b0;
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_cnt_reg    <= '0;
        end
        else
        begin
            flag_reg      <= flag_next;
            oq_wr_ptr_reg <= oq_wr_ptr_next;
            oq_rd_ptr_reg <= oq_rd_ptr_next;
            oq_cnt_reg    <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_wr)
        begin
            oq_reg[oq_wr_ptr_reg] <= oq_wdata;
        end
    end

`ifndef SYNTHESIS
    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_cnt_reg + in_flight) <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result slots overcommitted");
    a_oq_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        oq_wr |-> (oq_cnt_reg != OQ_CNT_W'(OQ_DEPTH)))
        else $error("result written into full queue");
    a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && s2_last_reg) |=> (flag_reg == 1'b0))
        else $error("parity not cleared after polygon result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/point_in_polygon_crossing.sv =====
`default_nettype none

// Crossing-number point-in-polygon test. Push one polygon vertex per request,
// in order, each with the same test point, and mark the final vertex with
// last_vertex; one result (inside_res, too_few) appears for each polygon, and
// polygons with fewer than three vertices report too_few with inside_res low.
// The block takes one vertex per cycle while full is low: a front stage tracks
// the first and previous vertex, a four-entry queue decouples it from a
// three-stage back pipeline (order by x, multiply, compare and toggle), and a
// four-entry result queue holds finished results. A closing vertex passes the
// queue and the order and multiply registers before its result is written to
// the result queue; full rises only when the result queue is not drained and
// the internal queues back up. No state needs clearing after reset.
module point_in_polygon_crossing (
    input  wire              clk,
    input  wire              rst_n,
    input  pip_pkg::coord_t  vertex_x,
    input  pip_pkg::coord_t  vertex_y,
    input  pip_pkg::coord_t  point_x,
    input  pip_pkg::coord_t  point_y,
    input  wire              last_vertex,
    input  wire              push,
    output logic             full,
    output logic             empty,
    input  wire              pop,
    output logic             inside_res,
    output logic             too_few
);
    import pip_pkg::*;

    mq_status_t mq_status;
    logic       mq_push;
    logic       mq_pop;
    edge_req_t  mq_wr_req;
    edge_req_t  mq_rd_req;

    pip_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_vertex (last_vertex),
        .push        (push),
        .full        (full),
        .mq_status   (mq_status),
        .mq_push     (mq_push),
        .mq_req      (mq_wr_req)
    );

    pip_mid_queue u_mid_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (mq_push),
        .wr_req (mq_wr_req),
        .rd_en  (mq_pop),
        .rd_req (mq_rd_req),
        .status (mq_status)
    );

    pip_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .mq_req     (mq_rd_req),
        .mq_status  (mq_status),
        .mq_pop     (mq_pop),
        .empty      (empty),
        .pop        (pop),
        .inside_res (inside_res),
        .too_few    (too_few)
    );

endmodule

`default_nettype wire

// ===== sim/tb_point_in_polygon_crossing.sv =====
`default_nettype none

module tb_point_in_polygon_crossing;
    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 400;

    typedef enum int
    {
        SPREAD_FULL,
        SPREAD_EXTREME,
        SPREAD_TINY,
        SPREAD_WINDOW
    } spread_t;

    typedef struct
    {
        coord_t vx;
        coord_t vy;
        coord_t px;
        coord_t py;
        bit     last;
    } vertex_t;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    coord_t vertex_x    = '0;
    coord_t vertex_y    = '0;
    coord_t point_x     = '0;
    coord_t point_y     = '0;
    logic   last_vertex = 1'b0;
    logic   push        = 1'b0;
    logic   pop         = 1'b0;
    logic   full;
    logic   empty;
    logic   inside_res;
    logic   too_few;

    // Crossing parity tracked per polygon
    coord_t first_x = '0;
    coord_t first_y = '0;
    coord_t prev_x  = '0;
    coord_t prev_y  = '0;
    bit     parity  = 1'b0;
    count_t seen    = '0;

    result_t verdicts[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_gen       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;

    int vertices_sent   = 0;
    int polygons_sent   = 0;
    int full_stalls     = 0;
    int results_checked = 0;
    int inside_seen     = 0;
    int too_few_seen    = 0;
    int mismatches      = 0;

    point_in_polygon_crossing DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .vertex_x    (vertex_x),
        .vertex_y    (vertex_y),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_vertex (last_vertex),
        .push        (push),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .inside_res  (inside_res),
        .too_few     (too_few)
    );

    always #CLK_HALF clk = ~clk;

    // Decide whether one edge flips the parity, in exact integer arithmetic
    function automatic bit edge_toggles(coord_t nx, coord_t ny, coord_t ox, coord_t oy,
                                        coord_t px, coord_t py);
        longint lx;
        longint ly;
        longint rx;
        longint ry;
        if (nx > ox)
        begin
            lx = ox;
            ly = oy;
            rx = nx;
            ry = ny;
        end
        else
        begin
            lx = nx;
            ly = ny;
            rx = ox;
            ry = oy;
        end
        if ((nx < px) != (px <= ox))
            return 1'b0;
        return ((longint'(py) - ly) * (rx - lx)) < ((ry - ly) * (longint'(px) - lx));
    endfunction

    // Advance the parity state by one vertex; queue a verdict on the closing one
    task automatic track_vertex(vertex_t v);
        bit      flip;
        count_t  n;
        result_t r;
        flip = parity;
        if (seen == 0)
        begin
            first_x = v.vx;
            first_y = v.vy;
        end
        else if (edge_toggles(v.vx, v.vy, prev_x, prev_y, v.px, v.py))
        begin
            flip = !flip;
        end
        n = (seen < MIN_VERTICES) ? count_t'(seen + 1) : count_t'(MIN_VERTICES);
        if (!v.last)
        begin
            parity = flip;
            seen   = n;
            prev_x = v.vx;
            prev_y = v.vy;
        end
        else
        begin
            if (edge_toggles(first_x, first_y, v.vx, v.vy, v.px, v.py))
                flip = !flip;
            if (n < MIN_VERTICES)
            begin
                r.in_poly = 1'b0;
                r.too_few = 1'b1;
            end
            else
            begin
                r.in_poly = flip;
                r.too_few = 1'b0;
            end
            verdicts.push_back(r);
            polygons_sent++;
            first_x = '0;
            first_y = '0;
            prev_x  = '0;
            prev_y  = '0;
            parity  = 1'b0;
            seen    = '0;
        end
    endtask

    // Offer one vertex after a random gap and hold the request until accepted
    task automatic push_vertex(vertex_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        vertex_x    <= v.vx;
        vertex_y    <= v.vy;
        point_x     <= v.px;
        point_y     <= v.py;
        last_vertex <= v.last;
        @(posedge clk);
        while (full)
        begin
            full_stalls++;
            @(posedge clk);
        end
        vertices_sent++;
        track_vertex(v);
    endtask

    // Drop the request, wait for every verdict, then let the pipeline settle
    task automatic finish_phase();
        push <= 1'b0;
        while (verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Send a closed ring of up to four vertices, packed as x,y pairs
    task automatic send_ring(int n, int ring[8], int px, int py);
        vertex_t v;
        for (int i = 0; i < n; i++)
        begin
            v.vx   = coord_t'(ring[2*i]);
            v.vy   = coord_t'(ring[2*i+1]);
            v.px   = coord_t'(px);
            v.py   = coord_t'(py);
            v.last = (i == n - 1);
            push_vertex(v);
        end
    endtask

    function automatic coord_t pick_coord(spread_t spread, int center, int radius);
        int extremes[8];
        int v;
        extremes = '{-32768, -32767, -2, -1, 0, 1, 32766, 32767};
        case (spread)
            SPREAD_FULL:    v = int'($urandom_range(0, 65535)) - 32768;
            SPREAD_EXTREME: v = extremes[$urandom_range(0, 7)];
            SPREAD_TINY:    v = int'($urandom_range(0, 8)) - 4;
            default:        v = center + int'($urandom_range(0, 2 * radius)) - radius;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return coord_t'(v);
    endfunction

    // Polygons of one and two vertices report too_few
    task automatic test_degenerate();
        send_ring(1, '{32767, -32768, 0, 0, 0, 0, 0, 0}, 0, 0);
        send_ring(2, '{-5, -5, 5, 5, 0, 0, 0, 0}, 0, 0);
        finish_phase();
    endtask

    task automatic test_triangles();
        send_ring(3, '{-100, -100, 100, -100, 0, 100, 0, 0}, 0, 0);
        send_ring(3, '{-100, -100, 100, -100, 0, 100, 0, 0}, 200, 0);
        finish_phase();
    endtask

    // Full-range square with the point at the center and on two corners
    task automatic test_extremes();
        send_ring(4, '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767}, 0, 0);
        send_ring(4, '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767},
                  -32768, -32768);
        send_ring(4, '{-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767},
                  32767, 32767);
        finish_phase();
    endtask

    // Move the test point on every vertex of one square
    task automatic test_changing_point();
        vertex_t v;
        int      ring[8];
        ring = '{-10, -10, 10, -10, 10, 10, -10, 10};
        for (int i = 0; i < 4; i++)
        begin
            v.vx   = coord_t'(ring[2*i]);
            v.vy   = coord_t'(ring[2*i+1]);
            v.px   = coord_t'(i * 7 - 9);
            v.py   = coord_t'(3 - i * 4);
            v.last = (i == 3);
            push_vertex(v);
        end
        finish_phase();
    endtask

    // Random polygons, mostly well formed, under one flow-control mix
    task automatic test_random_polygons(int budget, int idle_in, int idle_out);
        int      sent;
        int      n;
        int      roll;
        int      cx;
        int      cy;
        int      radius;
        spread_t spread;
        coord_t  px;
        coord_t  py;
        vertex_t v;
        send_idle_pct  = idle_in;
        recv_stall_pct = idle_out;
        sent = 0;
        while (sent < budget)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                n = 1;
            else if (roll < 8)
                n = 2;
            else if (roll < 80)
                n = $urandom_range(3, 6);
            else if (roll < 95)
                n = $urandom_range(7, 12);
            else
                n = $urandom_range(13, 24);
            spread = spread_t'($urandom_range(0, 3));
            cx     = int'($urandom_range(0, 65535)) - 32768;
            cy     = int'($urandom_range(0, 65535)) - 32768;
            radius = 1 << $urandom_range(2, 14);
            px = pick_coord(spread, cx, radius);
            py = pick_coord(spread, cy, radius);
            for (int i = 0; i < n; i++)
            begin
                // Now and then move the point in the middle of a polygon
                if ($urandom_range(19) == 0)
                begin
                    px = pick_coord(spread, cx, radius);
                    py = pick_coord(spread, cy, radius);
                end
                v.vx   = pick_coord(spread, cx, radius);
                v.vy   = pick_coord(spread, cy, radius);
                v.px   = px;
                v.py   = py;
                v.last = (i == n - 1);
                push_vertex(v);
            end
            sent += n;
        end
        finish_phase();
    endtask

    // Stall the output for a long stretch so the block fills and raises full
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_gen++;
        test_random_polygons(90, 0, 0);
    endtask

    // Count down a requested output hold
    always @(posedge clk)
    begin
        if (hold_gen != hold_ack)
        begin
            hold_ack  <= hold_gen;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Score each popped result against the oldest verdict, then pick next pop
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                results_checked++;
                if (inside_res)
                    inside_seen++;
                if (too_few)
                    too_few_seen++;
                if (verdicts.size() == 0)
                begin
                    $error("result with no polygon outstanding: inside_res=%0b too_few=%0b",
                           inside_res, too_few);
                    mismatches++;
                end
                else
                begin
                    want = verdicts.pop_front();
                    if (inside_res !== want.in_poly)
                    begin
                        $error("inside_res: expected %0b, got %0b", want.in_poly, inside_res);
                        mismatches++;
                    end
                    if (too_few !== want.too_few)
                    begin
                        $error("too_few: expected %0b, got %0b", want.too_few, too_few);
                        mismatches++;
                    end
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degenerate();
        test_triangles();
        test_extremes();
        test_changing_point();
        test_random_polygons(170, 0, 0);
        test_random_polygons(170, 60, 0);
        test_random_polygons(170, 0, 60);
        test_random_polygons(170, 8, 8);
        test_backpressure();

        $display("Streamed %0d vertices in %0d polygons; input held off %0d cycles by full.",
                 vertices_sent, polygons_sent, full_stalls);
        $display("Checked %0d results (%0d inside, %0d too few) with %0d mismatches.",
                 results_checked, inside_seen, too_few_seen, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
